/* src/krce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package krce_pkg;

    // Event kinds as they appear on the result stream.
    typedef enum logic [3:0] {
        KIND_PRESS       = 4'd0,
        KIND_RELEASE     = 4'd1,
        KIND_SUSTAIN     = 4'd2,
        KIND_STOMP       = 4'd3,
        KIND_MOD         = 4'd4,
        KIND_EXPRESSION  = 4'd5,
        KIND_ACCESSORIES = 4'd6,
        KIND_LOW_HAND    = 4'd7,
        KIND_HIGH_HAND   = 4'd8,
        KIND_ACCEL       = 4'd9
    } ev_kind_t;

    // One event as it waits in the pending and output registers.
    typedef struct packed {
        ev_kind_t    kind;
        logic [6:0]  note;
        logic [7:0]  value_a;
        logic [7:0]  value_b;
        logic [7:0]  value_c;
    } ev_t;

    localparam int BASE_NOTE   = 'h30;
    localparam int VEL_W       = 7;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CTRL_STEPS  = 8;
    localparam int CTRL_IDX_W  = $clog2(CTRL_STEPS);
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 6;
    localparam int IN_TUSER_W  = 2;

endpackage

`default_nettype wire

/* src/keyboard_report_change_events_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Keyboard report change detector. Each transaction on the slave stream is one
// controller report for one pad; the block compares it with the key, pedal and
// controller values it holds for that pad and sends one transaction per change
// on the master stream (key presses and releases in ascending note order, then
// sustain, stomp, mod, expression, accessories, low hand, high hand and one
// accelerometer event), with tlast on the final event of the report. At most
// 32 events are sent per report; state always follows the full report. While
// midi_port_mode is set, or for a pad number at or above PAD_COUNT, reports
// are taken and dropped. Rate: a report occupies the block for a load step,
// a scan step for each key and for each of the 8 controller values, and a
// flush step, because a single comparator and slot shifter step through one
// key or one controller value per cycle; the scan halts while the master side
// stalls as a new event is found, and the flush waits while the output
// register is still held. s_axis_tready is high only between reports.
module keyboard_report_change_events_core
    import krce_pkg::*;
#(
    parameter int PAD_COUNT  = 4,
    parameter int KEY_COUNT  = 25,
    parameter int SLOT_COUNT = 5
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic                   cfg_wr_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // key_bits, slot_velocities, sustain_in, stomp_in, mod_in, expression_in,
    // accessories_in, low_hand_in, high_hand_in, accel_axis_one, accel_axis_two
    input  wire logic [((KEY_COUNT + VEL_W * SLOT_COUNT + 54 + 7) / 8) * 8 - 1:0]
                                        s_axis_tdata,
    // pad
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // note, value_a, value_b, value_c
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // event_kind, event_pad
    output logic [OUT_TUSER_W-1:0]      m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int PAD_W     = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
    localparam int SLOT_W    = VEL_W * SLOT_COUNT;
    localparam int CTRL_W    = 54;
    localparam int O_SLOTS   = KEY_COUNT;
    localparam int O_SUS     = O_SLOTS + SLOT_W;
    localparam int O_STOMP   = O_SUS + 1;
    localparam int O_MOD     = O_STOMP + 1;
    localparam int O_EXPR    = O_MOD + 8;
    localparam int O_ACC     = O_EXPR + 8;
    localparam int O_LOW     = O_ACC + 8;
    localparam int O_HIGH    = O_LOW + 8;
    localparam int O_AX1     = O_HIGH + 4;
    localparam int O_AX2     = O_AX1 + 8;
    localparam logic [6:0] FIRST_NOTE = 7'(BASE_NOTE);
    localparam logic [6:0] LAST_NOTE  = 7'(BASE_NOTE + KEY_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYS,
        ST_CTRL,
        ST_FLUSH
    } state_t;

    // Input field views.
    logic [1:0]           in_pad;
    logic [KEY_COUNT-1:0] in_keys;
    logic [SLOT_W-1:0]    in_slots;
    logic                 in_sus;
    logic                 in_stomp;
    logic [7:0]           in_mod;
    logic [7:0]           in_expr;
    logic [7:0]           in_acc;
    logic [7:0]           in_low;
    logic [3:0]           in_high;
    logic [23:0]          in_accel;
    logic [PAD_W-1:0]     pad_idx;

    assign in_pad   = s_axis_tuser;
    assign in_keys  = s_axis_tdata[KEY_COUNT-1:0];
    assign in_slots = s_axis_tdata[O_SLOTS +: SLOT_W];
    assign in_sus   = s_axis_tdata[O_SUS];
    assign in_stomp = s_axis_tdata[O_STOMP];
    assign in_mod   = s_axis_tdata[O_MOD +: 8];
    assign in_expr  = s_axis_tdata[O_EXPR +: 8];
    assign in_acc   = s_axis_tdata[O_ACC +: 8];
    assign in_low   = s_axis_tdata[O_LOW +: 8];
    assign in_high  = s_axis_tdata[O_HIGH +: 4];
    assign in_accel = {s_axis_tdata[O_AX2 +: 8], s_axis_tdata[O_AX1 +: 8], in_mod};
    assign pad_idx  = PAD_W'(in_pad);

    // Per-pad stored values.
    logic [KEY_COUNT-1:0] key_down_reg    [PAD_COUNT];
    logic                 sustain_reg     [PAD_COUNT];
    logic                 stomp_reg       [PAD_COUNT];
    logic [7:0]           mod_reg         [PAD_COUNT];
    logic [7:0]           expression_reg  [PAD_COUNT];
    logic [7:0]           accessories_reg [PAD_COUNT];
    logic [7:0]           low_hand_reg    [PAD_COUNT];
    logic [3:0]           high_hand_reg   [PAD_COUNT];
    logic [23:0]          accel_reg       [PAD_COUNT];

    logic mode_reg;

    // Sequencer and working registers.
    state_t                state_reg, state_next;
    logic [1:0]            pad_reg, pad_next;
    logic [KEY_COUNT-1:0]  cur_keys_reg, cur_keys_next;
    logic [KEY_COUNT-1:0]  old_keys_reg, old_keys_next;
    logic [SLOT_W-1:0]     slots_reg, slots_next;
    logic [6:0]            note_reg, note_next;
    logic [CTRL_IDX_W-1:0] ctrl_idx_reg, ctrl_idx_next;
    logic [CNT_W-1:0]      found_reg, found_next;
    logic [CTRL_W-1:0]     new_ctrl_reg, new_ctrl_next;
    logic [CTRL_W-1:0]     old_ctrl_reg, old_ctrl_next;
    ev_t                   pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    ev_t                   out_reg, out_next;
    logic [1:0]            out_pad_reg, out_pad_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;

    logic       take_item;
    logic       start_scan;
    logic       key_now;
    logic       scanning;
    ev_kind_t   ctrl_kind;
    logic [23:0] cmp_new;
    logic [23:0] cmp_old;
    ev_t        cand;
    logic       hit;
    logic       keep;
    logic       out_free;
    logic       step_go;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign take_item     = s_axis_tvalid && s_axis_tready;
    assign start_scan    = take_item && !mode_reg && (32'(in_pad) < PAD_COUNT);

    // Shared compare unit: one key or one controller value per cycle unless
    // the scan stalls. Controller fields in the working words: sus, stomp,
    // mod, expr, acc, low, high, axis 1, axis 2 from bit 0 up.
    always_comb
    begin
        key_now   = cur_keys_reg[KEY_COUNT-1];
        ctrl_kind = ev_kind_t'(4'(KIND_SUSTAIN) + 4'(ctrl_idx_reg));
        cmp_new   = '0;
        cmp_old   = '0;
        cand      = '0;
        cand.kind = ctrl_kind;
        if (state_reg == ST_KEYS)
        begin
            cmp_new      = 24'(key_now);
            cmp_old      = 24'(old_keys_reg[KEY_COUNT-1]);
            cand.kind    = key_now ? KIND_PRESS : KIND_RELEASE;
            cand.note    = note_reg;
            cand.value_a = key_now ? 8'(slots_reg[VEL_W-1:0]) : 8'd0;
        end
        else
        begin
            unique case (ctrl_kind)
                KIND_SUSTAIN:
                begin
                    cmp_new = 24'(new_ctrl_reg[0]);
                    cmp_old = 24'(old_ctrl_reg[0]);
                end
                KIND_STOMP:
                begin
                    cmp_new = 24'(new_ctrl_reg[1]);
                    cmp_old = 24'(old_ctrl_reg[1]);
                end
                KIND_MOD:
                begin
                    cmp_new = 24'(new_ctrl_reg[9:2]);
                    cmp_old = 24'(old_ctrl_reg[9:2]);
                end
                KIND_EXPRESSION:
                begin
                    cmp_new = 24'(new_ctrl_reg[17:10]);
                    cmp_old = 24'(old_ctrl_reg[17:10]);
                end
                KIND_ACCESSORIES:
                begin
                    cmp_new = 24'(new_ctrl_reg[25:18]);
                    cmp_old = 24'(old_ctrl_reg[25:18]);
                end
                KIND_LOW_HAND:
                begin
                    cmp_new = 24'(new_ctrl_reg[33:26]);
                    cmp_old = 24'(old_ctrl_reg[33:26]);
                end
                KIND_HIGH_HAND:
                begin
                    cmp_new = 24'(new_ctrl_reg[37:34]);
                    cmp_old = 24'(old_ctrl_reg[37:34]);
                end
                KIND_ACCEL:
                begin
                    cmp_new = {new_ctrl_reg[53:38], new_ctrl_reg[9:2]};
                    cmp_old = {old_ctrl_reg[53:38], old_ctrl_reg[9:2]};
                end
                default:
                begin
                    cmp_new = '0;
                    cmp_old = '0;
                end
            endcase
            cand.value_a = cmp_new[7:0];
            if (ctrl_kind == KIND_ACCEL)
            begin
                cand.value_b = cmp_new[15:8];
                cand.value_c = cmp_new[23:16];
            end
        end
    end

    assign scanning = (state_reg == ST_KEYS) || (state_reg == ST_CTRL);
    assign hit      = scanning && (cmp_new != cmp_old);
    assign keep     = hit && (found_reg < CNT_W'(MAX_RESULTS));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign step_go  = !(keep && pend_valid_reg && !out_free);

    // Sequencer next state. One event waits in the pending register so that
    // the final one of a report can be sent with tlast.
    always_comb
    begin
        state_next      = state_reg;
        pad_next        = pad_reg;
        cur_keys_next   = cur_keys_reg;
        old_keys_next   = old_keys_reg;
        slots_next      = slots_reg;
        note_next       = note_reg;
        ctrl_idx_next   = ctrl_idx_reg;
        found_next      = found_reg;
        new_ctrl_next   = new_ctrl_reg;
        old_ctrl_next   = old_ctrl_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_pad_next    = out_pad_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_scan)
                begin
                    pad_next      = in_pad;
                    cur_keys_next = in_keys;
                    old_keys_next = key_down_reg[pad_idx];
                    slots_next    = in_slots;
                    note_next     = FIRST_NOTE;
                    ctrl_idx_next = '0;
                    found_next    = '0;
                    new_ctrl_next = {in_accel[23:8], in_high, in_low, in_acc,
                                     in_expr, in_mod, in_stomp, in_sus};
                    old_ctrl_next = {accel_reg[pad_idx][23:8], high_hand_reg[pad_idx],
                                     low_hand_reg[pad_idx], accessories_reg[pad_idx],
                                     expression_reg[pad_idx], mod_reg[pad_idx],
                                     stomp_reg[pad_idx], sustain_reg[pad_idx]};
                    state_next    = ST_KEYS;
                end
            end
            ST_KEYS, ST_CTRL:
            begin
                if (step_go)
                begin
                    if (keep)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_pad_next   = pad_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = cand;
                        pend_valid_next = 1'b1;
                        found_next      = found_reg + CNT_W'(1);
                    end
                    if (state_reg == ST_KEYS)
                    begin
                        cur_keys_next = cur_keys_reg << 1;
                        old_keys_next = old_keys_reg << 1;
                        if (key_now)
                        begin
                            slots_next = slots_reg >> VEL_W;
                        end
                        note_next = note_reg + 7'd1;
                        if (note_reg == LAST_NOTE)
                        begin
                            state_next = ST_CTRL;
                        end
                    end
                    else
                    begin
                        ctrl_idx_next = ctrl_idx_reg + CTRL_IDX_W'(1);
                        if (ctrl_idx_reg == CTRL_IDX_W'(CTRL_STEPS - 1))
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_pad_next    = pad_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, stored pad values and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= 1'b0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pad_reg        <= '0;
            cur_keys_reg   <= '0;
            old_keys_reg   <= '0;
            slots_reg      <= '0;
            note_reg       <= '0;
            ctrl_idx_reg   <= '0;
            new_ctrl_reg   <= '0;
            old_ctrl_reg   <= '0;
            pend_reg       <= '0;
            out_reg        <= '0;
            out_pad_reg    <= '0;
            out_last_reg   <= 1'b0;
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                key_down_reg[p]    <= '0;
                sustain_reg[p]     <= 1'b0;
                stomp_reg[p]       <= 1'b0;
                mod_reg[p]         <= '0;
                expression_reg[p]  <= '0;
                accessories_reg[p] <= '0;
                low_hand_reg[p]    <= '0;
                high_hand_reg[p]   <= '0;
                accel_reg[p]       <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            pad_reg        <= pad_next;
            cur_keys_reg   <= cur_keys_next;
            old_keys_reg   <= old_keys_next;
            slots_reg      <= slots_next;
            note_reg       <= note_next;
            ctrl_idx_reg   <= ctrl_idx_next;
            new_ctrl_reg   <= new_ctrl_next;
            old_ctrl_reg   <= old_ctrl_next;
            pend_reg       <= pend_next;
            out_reg        <= out_next;
            out_pad_reg    <= out_pad_next;
            out_last_reg   <= out_last_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            // The stored values take the report when the scan starts.
            if (start_scan)
            begin
                key_down_reg[pad_idx]    <= in_keys;
                sustain_reg[pad_idx]     <= in_sus;
                stomp_reg[pad_idx]       <= in_stomp;
                mod_reg[pad_idx]         <= in_mod;
                expression_reg[pad_idx]  <= in_expr;
                accessories_reg[pad_idx] <= in_acc;
                low_hand_reg[pad_idx]    <= in_low;
                high_hand_reg[pad_idx]   <= in_high;
                accel_reg[pad_idx]       <= in_accel;
            end
        end
    end

    // Output stream.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {1'b0, out_reg.value_c, out_reg.value_b, out_reg.value_a,
                            out_reg.note};
    assign m_axis_tuser  = {out_pad_reg, out_reg.kind};

    // Nothing may be left pending once the block takes a new report.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_valid_reg)
        else $error("event left pending while idle");

    // The event count of one report never passes the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= CNT_W'(MAX_RESULTS))
        else $error("event count past limit");

    // Key events carry a note in the keyboard range, other events carry none.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_reg.kind == KIND_PRESS || out_reg.kind == KIND_RELEASE))
        |-> (out_reg.note >= FIRST_NOTE && out_reg.note <= LAST_NOTE))
        else $error("key event note out of range");

    // A report dropped in port mode leaves the block ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take_item && mode_reg) |=> s_axis_tready)
        else $error("dropped report started a scan");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import krce_pkg::*;

    localparam int PADS = 4;
    localparam int KEYS = 25;
    localparam int SLOTS = 5;
    localparam int IN_TDATA_W = ((KEYS + VEL_W * SLOTS + 54 + 7) / 8) * 8;

    // Run control
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int CFG_SETTLE = 45;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_REPORTS = 228;

    // Ways of building a random report from the state held for a pad
    localparam int SHAPE_SAME = 0;
    localparam int SHAPE_SMALL = 1;
    localparam int SHAPE_FLIP_ALL = 2;
    localparam int SHAPE_WILD = 3;

    // One controller report as the sender sees it.
    typedef struct {
        logic [1:0]      pad;
        logic [KEYS-1:0] key_bits;
        logic [34:0]     slots;
        logic            sustain;
        logic            stomp;
        logic [7:0]      mod;
        logic [7:0]      expr;
        logic [7:0]      acc;
        logic [7:0]      low;
        logic [3:0]      high;
        logic [7:0]      ax1;
        logic [7:0]      ax2;
    } report_t;

    // One change event as the receiver expects it.
    typedef struct {
        ev_kind_t   kind;
        logic [1:0] pad;
        logic [6:0] note;
        logic [7:0] value_a;
        logic [7:0] value_b;
        logic [7:0] value_c;
        logic       last;
    } change_t;

    // Tracks per-pad key and controller state and the change events still due.
    class change_scoreboard;
        logic [KEYS-1:0] keys_held [PADS];
        logic            sustain_st [PADS];
        logic            stomp_st [PADS];
        logic [7:0]      mod_st [PADS];
        logic [7:0]      expr_st [PADS];
        logic [7:0]      acc_st [PADS];
        logic [7:0]      low_st [PADS];
        logic [3:0]      high_st [PADS];
        logic [23:0]     accel_st [PADS];
        logic            midi_mode;
        change_t         changes_due [$];
        change_t         batch [$];
        int              errors;

        function new();
            for (int p = 0; p < PADS; p++)
            begin
                keys_held[p] = '0;
                sustain_st[p] = 1'b0;
                stomp_st[p] = 1'b0;
                mod_st[p] = '0;
                expr_st[p] = '0;
                acc_st[p] = '0;
                low_st[p] = '0;
                high_st[p] = '0;
                accel_st[p] = '0;
            end
            midi_mode = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return changes_due.size();
        endfunction

        // Events beyond the per-report limit are dropped, state still follows.
        function void add_change(ev_kind_t kind, logic [1:0] pad, logic [6:0] note,
                                 logic [7:0] a, logic [7:0] b, logic [7:0] c);
            change_t e;
            if (batch.size() >= MAX_RESULTS)
                return;
            e.kind = kind;
            e.pad = pad;
            e.note = note;
            e.value_a = a;
            e.value_b = b;
            e.value_c = c;
            e.last = 1'b0;
            batch.push_back(e);
        endfunction

        // Works out the events of one accepted report and updates the pad state.
        function void note_report(report_t r);
            int         p;
            int         slot;
            logic       now_dn;
            logic       was_dn;
            logic [6:0] nt;
            logic [7:0] vel;
            logic [34:0] shifted;
            logic [23:0] accel;
            change_t    e;
            if (midi_mode)
                return;
            p = int'(r.pad);
            slot = 1;
            batch.delete();

            // Keys in ascending note order; every held key uses up a slot.
            for (int k = 0; k < KEYS; k++)
            begin
                now_dn = r.key_bits[KEYS-1-k];
                was_dn = keys_held[p][KEYS-1-k];
                nt = 7'(BASE_NOTE + k);
                if (now_dn != was_dn)
                begin
                    if (now_dn)
                    begin
                        shifted = r.slots >> (VEL_W * (slot - 1));
                        vel = (slot <= SLOTS) ? {1'b0, shifted[VEL_W-1:0]} : 8'd0;
                        add_change(KIND_PRESS, r.pad, nt, vel, 8'd0, 8'd0);
                        slot++;
                    end
                    else
                    begin
                        add_change(KIND_RELEASE, r.pad, nt, 8'd0, 8'd0, 8'd0);
                    end
                end
                else if (now_dn)
                begin
                    slot++;
                end
            end
            keys_held[p] = r.key_bits;

            // Pedals and controllers in fixed order.
            if (r.sustain != sustain_st[p])
            begin
                sustain_st[p] = r.sustain;
                add_change(KIND_SUSTAIN, r.pad, 7'd0, {7'd0, r.sustain}, 8'd0, 8'd0);
            end
            if (r.stomp != stomp_st[p])
            begin
                stomp_st[p] = r.stomp;
                add_change(KIND_STOMP, r.pad, 7'd0, {7'd0, r.stomp}, 8'd0, 8'd0);
            end
            if (r.mod != mod_st[p])
            begin
                mod_st[p] = r.mod;
                add_change(KIND_MOD, r.pad, 7'd0, r.mod, 8'd0, 8'd0);
            end
            if (r.expr != expr_st[p])
            begin
                expr_st[p] = r.expr;
                add_change(KIND_EXPRESSION, r.pad, 7'd0, r.expr, 8'd0, 8'd0);
            end
            if (r.acc != acc_st[p])
            begin
                acc_st[p] = r.acc;
                add_change(KIND_ACCESSORIES, r.pad, 7'd0, r.acc, 8'd0, 8'd0);
            end
            if (r.low != low_st[p])
            begin
                low_st[p] = r.low;
                add_change(KIND_LOW_HAND, r.pad, 7'd0, r.low, 8'd0, 8'd0);
            end
            if (r.high != high_st[p])
            begin
                high_st[p] = r.high;
                add_change(KIND_HIGH_HAND, r.pad, 7'd0, {4'd0, r.high}, 8'd0, 8'd0);
            end

            // The accelerometer uses the mod byte as its first axis.
            accel = {r.ax2, r.ax1, r.mod};
            if (accel != accel_st[p])
            begin
                accel_st[p] = accel;
                add_change(KIND_ACCEL, r.pad, 7'd0, r.mod, r.ax1, r.ax2);
            end

            if (batch.size() > 0)
            begin
                e = batch.pop_back();
                e.last = 1'b1;
                batch.push_back(e);
            end
            foreach (batch[j])
                changes_due.push_back(batch[j]);
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Compares one received event with the oldest one still due.
        task check_result(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user,
                          logic lst);
            change_t want;
            if (changes_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected event kind %0d pad %0d data 0x%0h",
                                          user[3:0], user[5:4], data));
                return;
            end
            want = changes_due.pop_front();
            if (user[3:0] !== want.kind)
                report_mismatch($sformatf("kind got %0d, expected %0d",
                                          user[3:0], want.kind));
            if (user[5:4] !== want.pad)
                report_mismatch($sformatf("pad got %0d, expected %0d", user[5:4], want.pad));
            if (data[6:0] !== want.note)
                report_mismatch($sformatf("note got %0d, expected %0d",
                                          data[6:0], want.note));
            if (data[14:7] !== want.value_a)
                report_mismatch($sformatf("value_a got 0x%0h, expected 0x%0h",
                                          data[14:7], want.value_a));
            if (data[22:15] !== want.value_b)
                report_mismatch($sformatf("value_b got 0x%0h, expected 0x%0h",
                                          data[22:15], want.value_b));
            if (data[30:23] !== want.value_c)
                report_mismatch($sformatf("value_c got 0x%0h, expected 0x%0h",
                                          data[30:23], want.value_c));
            if (lst !== want.last)
                report_mismatch($sformatf("tlast got %0b, expected %0b", lst, want.last));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic                   cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // key_bits, slot_velocities, sustain_in, stomp_in, mod_in, expression_in,
    // accessories_in, low_hand_in, high_hand_in, accel_axis_one, accel_axis_two
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // pad
    logic [IN_TUSER_W-1:0]  s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // note, value_a, value_b, value_c
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // event_kind, event_pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    change_scoreboard events_sb;
    logic idle_on = 1'b1;
    logic squeeze_req = 1'b0;
    int   cycles = 0;

    keyboard_report_change_events_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("** keyboard_report_change_events_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pack_report(report_t r);
        return {6'd0, r.ax2, r.ax1, r.high, r.low, r.acc, r.expr, r.mod,
                r.stomp, r.sustain, r.slots, r.key_bits};
    endfunction

    function automatic report_t blank_report(logic [1:0] pad);
        report_t r;
        r.pad = pad;
        r.key_bits = '0;
        r.slots = '0;
        r.sustain = 1'b0;
        r.stomp = 1'b0;
        r.mod = '0;
        r.expr = '0;
        r.acc = '0;
        r.low = '0;
        r.high = '0;
        r.ax1 = '0;
        r.ax2 = '0;
        return r;
    endfunction

    // Builds a report from the state currently held for the pad.
    function automatic report_t shape_report(logic [1:0] pad, int shape);
        report_t r;
        int      flips;
        r.pad = pad;
        r.key_bits = events_sb.keys_held[pad];
        r.slots = 35'({$urandom, $urandom});
        r.sustain = events_sb.sustain_st[pad];
        r.stomp = events_sb.stomp_st[pad];
        r.mod = events_sb.mod_st[pad];
        r.expr = events_sb.expr_st[pad];
        r.acc = events_sb.acc_st[pad];
        r.low = events_sb.low_st[pad];
        r.high = events_sb.high_st[pad];
        r.ax1 = events_sb.accel_st[pad][15:8];
        r.ax2 = events_sb.accel_st[pad][23:16];
        if (shape == SHAPE_SMALL)
        begin
            flips = $urandom_range(0, 3);
            for (int j = 0; j < flips; j++)
                r.key_bits[$urandom_range(0, KEYS - 1)] ^= 1'b1;
            if ($urandom_range(9) == 0) r.sustain = ~r.sustain;
            if ($urandom_range(9) == 0) r.stomp = ~r.stomp;
            if ($urandom_range(9) == 0) r.mod = 8'($urandom);
            if ($urandom_range(9) == 0) r.expr = 8'($urandom);
            if ($urandom_range(9) == 0) r.acc = 8'($urandom);
            if ($urandom_range(9) == 0) r.low = 8'($urandom);
            if ($urandom_range(9) == 0) r.high = 4'($urandom);
            if ($urandom_range(9) == 0) r.ax1 = 8'($urandom);
            if ($urandom_range(9) == 0) r.ax2 = 8'($urandom);
        end
        else if (shape == SHAPE_FLIP_ALL)
        begin
            r.key_bits = ~r.key_bits;
            r.sustain = ~r.sustain;
            r.stomp = ~r.stomp;
            r.mod = ~r.mod;
            r.expr = ~r.expr;
            r.acc = ~r.acc;
            r.low = ~r.low;
            r.high = ~r.high;
        end
        else if (shape == SHAPE_WILD)
        begin
            r.key_bits = KEYS'($urandom);
            r.sustain = 1'($urandom);
            r.stomp = 1'($urandom);
            r.mod = 8'($urandom);
            r.expr = 8'($urandom);
            r.acc = 8'($urandom);
            r.low = 8'($urandom);
            r.high = 4'($urandom);
            r.ax1 = 8'($urandom);
            r.ax2 = 8'($urandom);
        end
        return r;
    endfunction

    // Offers one report, optionally after an idle gap, and waits for the transaction.
    task automatic send_report(report_t r);
        if (idle_on && $urandom_range(99) < 8)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pack_report(r);
        s_axis_tuser <= r.pad;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        events_sb.note_report(r);
    endtask

    // Writes the mode register once the block has drained and gone quiet.
    task automatic write_mode(logic mode);
        s_axis_tvalid <= 1'b0;
        while (events_sb.pending() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        events_sb.midi_mode = mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: checks every event and stalls at random or for one long hold.
    initial
    begin : receiver
        int   hold_left;
        logic hold_done;
        m_axis_tready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                events_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (squeeze_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < 8);
            end
        end
    end

    // Stimulus: reset, directed reports, then random reports across mode changes.
    initial
    begin
        report_t r;
        int      pick;
        events_sb = new();
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_mode(1'b0);

        // A report equal to the reset state changes nothing.
        r = blank_report(2'd0);
        send_report(r);

        // Three presses with extreme and middle slot velocities.
        r.key_bits = 25'h1420000;
        r.slots = {7'h00, 7'h00, 7'h55, 7'h00, 7'h7F};
        send_report(r);

        // Eight keys down: the sixth and later ones get no velocity; note 72 included.
        r.key_bits = 25'h1F20003;
        r.slots = {7'd5, 7'd4, 7'd3, 7'd2, 7'd1};
        send_report(r);

        // Releases down to the top note alone.
        r.key_bits = 25'h0000001;
        send_report(r);

        // Each pedal and controller on its own, each axis on its own.
        r.sustain = 1'b1;
        send_report(r);
        r.stomp = 1'b1;
        send_report(r);
        r.mod = 8'hFF;
        send_report(r);
        r.expr = 8'hFF;
        send_report(r);
        r.acc = 8'hFF;
        send_report(r);
        r.low = 8'hFF;
        send_report(r);
        r.high = 4'hF;
        send_report(r);
        r.ax1 = 8'hFF;
        send_report(r);
        r.ax2 = 8'hFF;
        send_report(r);
        send_report(blank_report(2'd0));

        // Everything changes at once: more events than one report may carry.
        r = blank_report(2'd1);
        r.key_bits = '1;
        r.slots = '1;
        r.sustain = 1'b1;
        r.stomp = 1'b1;
        r.mod = 8'hFF;
        r.expr = 8'hFF;
        r.acc = 8'hFF;
        r.low = 8'hFF;
        r.high = 4'hF;
        r.ax1 = 8'hFF;
        r.ax2 = 8'hFF;
        send_report(r);
        send_report(blank_report(2'd1));

        // The other pads, then an unchanged repeat.
        r = blank_report(2'd2);
        r.key_bits = 25'h0AAAAAA;
        r.slots = 35'h2_AAAA_AAAA;
        r.sustain = 1'b1;
        send_report(r);
        r = blank_report(2'd3);
        r.key_bits = 25'h1555555;
        r.slots = 35'h5_5555_5555;
        r.ax2 = 8'h80;
        send_report(r);
        send_report(r);

        // Reports are dropped in port mode and leave the state alone.
        write_mode(1'b1);
        r = blank_report(2'd0);
        r.key_bits = 25'h0F0F0F0;
        r.mod = 8'h42;
        send_report(r);
        send_report(blank_report(2'd3));
        write_mode(1'b0);
        send_report(blank_report(2'd3));

        // Random reports, mostly small steps from the held state.
        for (int i = 0; i < RANDOM_REPORTS; i++)
        begin
            if (i == 60)
                squeeze_req = 1'b1;
            idle_on = !(i >= 120 && i < 180);
            if (i == 200)
                write_mode(1'b1);
            if (i == 215)
                write_mode(1'b0);
            pick = $urandom_range(99);
            if (pick < 70)
                r = shape_report(2'($urandom_range(PADS - 1)), SHAPE_SMALL);
            else if (pick < 85)
                r = shape_report(2'($urandom_range(PADS - 1)), SHAPE_WILD);
            else if (pick < 95)
                r = shape_report(2'($urandom_range(PADS - 1)), SHAPE_SAME);
            else
                r = shape_report(2'($urandom_range(PADS - 1)), SHAPE_FLIP_ALL);
            send_report(r);
        end

        // Drain the result stream, then allow for any trailing activity.
        s_axis_tvalid <= 1'b0;
        while (events_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (events_sb.errors == 0)
            $display("** keyboard_report_change_events_core: PASSED **");
        else
            $display("** keyboard_report_change_events_core: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
src/krce_pkg.sv
src/keyboard_report_change_events_core.sv
test/tb.sv
